### src/cte_pkg.sv
package cte_pkg;

   localparam int NUM_STATES = 20;
   localparam int NUM_TERMS = 13;
   localparam int COEF_WIDTH = 32;

   localparam int STATE_WIDTH = 5;
   localparam int TERM_WIDTH = 6;
   localparam int COEF_IN_WIDTH = 32;
   localparam int BRANCH_WIDTH = 32;
   localparam int RES_WIDTH = 32;

   localparam int PAIR_COUNT = NUM_STATES * NUM_STATES;
   localparam int PAIR_ADDR_WIDTH = $clog2(PAIR_COUNT);

   localparam int ACC_WIDTH = 58;
   localparam int Y_WIDTH = BRANCH_WIDTH + 1;
   localparam int DL_WIDTH = 29;
   localparam int DH_WIDTH = ACC_WIDTH - DL_WIDTH;
   localparam int PH_WIDTH = DH_WIDTH + Y_WIDTH;
   localparam int PL_WIDTH = DL_WIDTH + 1 + Y_WIDTH;
   localparam int PROD_WIDTH = ACC_WIDTH + Y_WIDTH;
   localparam int SUM_WIDTH = ACC_WIDTH + 3;
   localparam int FINAL_SHIFT = BRANCH_WIDTH - 1;
   localparam int STEP_SHIFT = FINAL_SHIFT - 1;
   localparam int SAT_WIDTH = (COEF_WIDTH > COEF_IN_WIDTH ? COEF_WIDTH : COEF_IN_WIDTH) + 1;

   localparam logic signed [SUM_WIDTH-1:0] ACC_HI =
      (SUM_WIDTH'(1) << (ACC_WIDTH - 1)) - SUM_WIDTH'(1);
   localparam logic signed [SUM_WIDTH-1:0] OUT_HI =
      (SUM_WIDTH'(1) << (RES_WIDTH - 1)) - SUM_WIDTH'(1);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   typedef struct packed {
      logic                              valid;
      logic                              evaluate;
      logic                              ok;
      logic [PAIR_ADDR_WIDTH-1:0]        addr;
      logic [TERM_WIDTH-1:0]             term;
      logic signed [COEF_WIDTH-1:0]      coef;
      logic signed [Y_WIDTH-1:0]         y;
      logic signed [ACC_WIDTH-1:0]       d;
      logic signed [ACC_WIDTH-1:0]       dd;
   } item_type;

   function automatic logic signed [COEF_WIDTH-1:0] coef_sat(
      input logic signed [COEF_IN_WIDTH-1:0] v
   );
      logic signed [SAT_WIDTH-1:0] w;
      logic signed [SAT_WIDTH-1:0] hi;
      w = SAT_WIDTH'(v);
      hi = (SAT_WIDTH'(1) << (COEF_WIDTH - 1)) - SAT_WIDTH'(1);
      if (w > hi) begin
         w = hi;
      end else if (w < ~hi) begin
         w = ~hi;
      end
      return COEF_WIDTH'(w);
   endfunction

endpackage

### src/cte_req_if.sv
interface cte_req_if;
   import cte_pkg::*;

   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [STATE_WIDTH-1:0]          from_state;
   logic [STATE_WIDTH-1:0]          to_state;
   logic [TERM_WIDTH-1:0]           term_index;
   logic signed [COEF_IN_WIDTH-1:0] coef_value;
   logic [BRANCH_WIDTH-1:0]         branch_length;

   modport source (
      output valid, kind, from_state, to_state, term_index, coef_value, branch_length,
      input  ready
   );

   modport sink (
      input  valid, kind, from_state, to_state, term_index, coef_value, branch_length,
      output ready
   );
endinterface

### src/cte_rsp_if.sv
interface cte_rsp_if;
   import cte_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [RES_WIDTH-1:0] probability;
   logic                        bad_index;

   modport source (
      output valid, probability, bad_index,
      input  ready
   );

   modport sink (
      input  valid, probability, bad_index,
      output ready
   );
endinterface

### src/cte_ram.sv
module cte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 400
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### src/cte_entry.sv
module cte_entry (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   cte_req_if.sink           req_if,
   output cte_pkg::item_type entry_item
);
   import cte_pkg::*;

   item_type                   entry_ff;
   item_type                   entry_in;
   logic                       from_ok;
   logic                       to_ok;
   logic [STATE_WIDTH-1:0]     from_m1;
   logic [STATE_WIDTH-1:0]     to_m1;
   logic signed [Y_WIDTH:0]    y_wide;

   assign req_if.ready = advance && !reset;

   assign from_ok = (req_if.from_state != '0) &&
                    (32'(req_if.from_state) <= NUM_STATES);
   assign to_ok   = (req_if.to_state != '0) &&
                    (32'(req_if.to_state) <= NUM_STATES);
   assign from_m1 = req_if.from_state - STATE_WIDTH'(1);
   assign to_m1   = req_if.to_state - STATE_WIDTH'(1);

   // y = 1 - t
   assign y_wide = $signed({3'b001, {(BRANCH_WIDTH-1){1'b0}}}) -
                   $signed({2'b00, req_if.branch_length});

   always_comb begin
      entry_in          = entry_ff;
      entry_in.valid    = req_if.valid && req_if.ready;
      entry_in.evaluate = (req_if.kind == KIND_EVAL);
      entry_in.ok       = from_ok && to_ok;
      entry_in.addr     = PAIR_ADDR_WIDTH'(32'(from_m1) * NUM_STATES + 32'(to_m1));
      entry_in.term     = req_if.term_index;
      entry_in.coef     = coef_sat(req_if.coef_value);
      entry_in.y        = y_wide[Y_WIDTH-1:0];
      entry_in.d        = '0;
      entry_in.dd       = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_item = entry_ff;
endmodule

### src/cte_step.sv
module cte_step (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [cte_pkg::TERM_WIDTH-1:0] term_id,
   input  logic                           last,
   input  cte_pkg::item_type              in_item,
   output cte_pkg::item_type              out_item
);
   import cte_pkg::*;

   item_type                     a_ff;
   item_type                     b_ff;
   item_type                     c_ff;
   item_type                     c_in;
   logic signed [PH_WIDTH-1:0]   ph_ff;
   logic signed [PH_WIDTH-1:0]   ph_in;
   logic signed [PL_WIDTH-1:0]   pl_ff;
   logic signed [PL_WIDTH-1:0]   pl_in;
   logic signed [SUM_WIDTH-1:0]  prod_ff;
   logic signed [SUM_WIDTH-1:0]  prod_in;
   logic signed [SUM_WIDTH-1:0]  cmd_ff;
   logic signed [SUM_WIDTH-1:0]  cmd_in;
   logic signed [PROD_WIDTH-1:0] full;
   logic signed [COEF_WIDTH-1:0] coef_rd;
   logic signed [COEF_WIDTH-1:0] coef_term;
   logic signed [SUM_WIDTH-1:0]  sum;
   logic signed [SUM_WIDTH-1:0]  hi;
   logic signed [SUM_WIDTH-1:0]  lo;
   logic signed [DH_WIDTH-1:0]   dh;
   logic signed [DL_WIDTH:0]     dl;
   logic                         wr_en;

   // a load writes its term as it passes, so reads and writes keep item order
   assign wr_en = advance && in_item.valid && !in_item.evaluate && in_item.ok &&
                  (in_item.term == term_id);

   cte_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (PAIR_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (in_item.addr),
      .wr_data (in_item.coef),
      .rd_en   (advance),
      .rd_addr (in_item.addr),
      .rd_data (coef_rd)
   );

   // stage a: split partial products of d * y
   assign dh    = in_item.d[ACC_WIDTH-1 -: DH_WIDTH];
   assign dl    = {1'b0, in_item.d[DL_WIDTH-1:0]};
   assign ph_in = dh * $signed(in_item.y);
   assign pl_in = dl * $signed(in_item.y);

   // stage b: combine and scale, fold coefficient and dd
   assign full = (PROD_WIDTH'(ph_ff) <<< DL_WIDTH) + PROD_WIDTH'(pl_ff);
   assign prod_in = last ? SUM_WIDTH'(full >>> FINAL_SHIFT) : SUM_WIDTH'(full >>> STEP_SHIFT);
   assign coef_term = last ? (coef_rd >>> 1) : coef_rd;
   assign cmd_in = SUM_WIDTH'(coef_term) - SUM_WIDTH'($signed(a_ff.dd));

   // stage c: sum and saturate
   assign sum = prod_ff + cmd_ff;
   assign hi  = last ? OUT_HI : ACC_HI;
   assign lo  = ~hi;

   always_comb begin
      c_in    = b_ff;
      c_in.dd = b_ff.d;
      if (sum > hi) begin
         c_in.d = ACC_WIDTH'(hi);
      end else if (sum < lo) begin
         c_in.d = ACC_WIDTH'(lo);
      end else begin
         c_in.d = ACC_WIDTH'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff  <= in_item;
         ph_ff <= ph_in;
         pl_ff <= pl_in;
         b_ff    <= a_ff;
         prod_ff <= prod_in;
         cmd_ff  <= cmd_in;
         c_ff <= c_in;
      end
   end

   assign out_item = c_ff;
endmodule

### src/chebyshev_transition_prob_eval.sv
// Chebyshev series evaluator for transition probabilities.
// req_if carries one beat per item: kind 0 loads coef_value as term term_index of the
// pair (from_state, to_state); kind 1 evaluates the series of that pair at y = 1 - t,
// t = branch_length, by the Clenshaw recurrence. Loads with a state outside 1..20 or
// a term above 13 change nothing. Loads give no beat on rsp_if; every evaluate gives
// exactly one, in order, with probability (Q4.28, saturated) and bad_index.
// Pipeline: the entry stage loads at the accepting edge, then three stages follow
// for each of the 14 terms (multiply, scale, add and saturate), and the result beat
// is presented from the last one. A new beat is taken every cycle while not held.
// Each term stage owns a coefficient memory of 400 entries (one per state pair);
// a load writes it when the load passes that stage, so an evaluate always sees the
// loads that came before it. Coefficients read before being loaded are undefined.
// Reset clears the valid bits of all stages; the memories keep their contents.
// req_if.ready is low during reset. When rsp_if holds a beat that is not taken,
// the whole pipeline holds and req_if.ready drops.
module chebyshev_transition_prob_eval (
   input  logic      clock,
   input  logic      reset,
   cte_req_if.sink   req_if,
   cte_rsp_if.source rsp_if
);
   import cte_pkg::*;

   item_type chain [NUM_TERMS+2];
   item_type last_item;
   logic     advance;

   assign last_item = chain[NUM_TERMS+1];
   assign advance   = !rsp_if.valid || rsp_if.ready;

   cte_entry u_entry (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_if     (req_if),
      .entry_item (chain[0])
   );

   for (genvar k = 0; k <= NUM_TERMS; k++) begin : g_step
      cte_step u_step (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .term_id  (TERM_WIDTH'(NUM_TERMS - k)),
         .last     (k == NUM_TERMS),
         .in_item  (chain[k]),
         .out_item (chain[k+1])
      );
   end

   assign rsp_if.valid       = last_item.valid && last_item.evaluate;
   assign rsp_if.probability = last_item.ok ? last_item.d[RES_WIDTH-1:0] : '0;
   assign rsp_if.bad_index   = !last_item.ok;
endmodule

### src/cte_checker.sv
module cte_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [cte_pkg::RES_WIDTH-1:0] rsp_probability,
   input logic                                rsp_bad_index
);
   import cte_pkg::*;

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_probability) && $stable(rsp_bad_index))
      else $error("result beat changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_probability == '0)
      else $error("bad index with nonzero probability");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled while output can move");

   a_no_take_reset: assert property (@(posedge clock)
      reset |-> !req_ready)
      else $error("request taken during reset");
endmodule

bind chebyshev_transition_prob_eval cte_checker u_cte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_probability (rsp_if.probability),
   .rsp_bad_index   (rsp_if.bad_index)
);
